// ===== rtl/core/vif_pkg.sv =====
// shared types, constants and helpers of the velocity integrator
package vif_pkg;

  localparam int unsigned DW       = 32;
  localparam int unsigned DT_W     = 16;
  localparam int unsigned LIM_W    = 31;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DEADBAND = 1;

  localparam logic [LIM_W-1:0] FULL_SCALE = '1;

  typedef enum logic [1:0] {
    FN_TICK    = 2'd0,
    FN_IMPULSE = 2'd1,
    FN_SET     = 2'd2,
    FN_STOP    = 2'd3
  } vif_func_t;

  typedef enum logic [2:0] {
    REG_FORCE_X     = 3'd0,
    REG_FORCE_Y     = 3'd1,
    REG_MASS        = 3'd2,
    REG_GRAVITY_X   = 3'd3,
    REG_GRAVITY_Y   = 3'd4,
    REG_FRICTION    = 3'd5,
    REG_MAX_SPEED_X = 3'd6,
    REG_MAX_SPEED_Y = 3'd7
  } vif_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DV,
    ST_SUM,
    ST_FRIC,
    ST_LIM,
    ST_PROD,
    ST_MOVE,
    ST_DONE
  } vif_state_t;

  // per-cycle step enables from the sequencer to both lanes
  typedef struct packed {
    logic load;
    logic acc;
    logic dv;
    logic sum;
    logic fric;
    logic lim;
    logic prod;
    logic move;
  } vif_lane_ctrl_t;

  // saturate a 33-bit signed sum to 32 bits
  function automatic logic [DW-1:0] sat33(input logic [DW:0] v);
    logic [DW-1:0] r;
    if (v[DW] != v[DW-1]) begin
      r = v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/vif_in_if.sv =====
// input item channel: valid/ready plus item payload
interface vif_in_if;
  import vif_pkg::*;

  logic                 valid;
  logic                 ready;
  vif_func_t            func;
  logic [DT_W-1:0]      time_step;
  logic signed [DW-1:0] vec_x;
  logic signed [DW-1:0] vec_y;

  modport source (output valid, func, time_step, vec_x, vec_y, input ready);
  modport sink   (input valid, func, time_step, vec_x, vec_y, output ready);
endinterface

// ===== rtl/core/vif_out_if.sv =====
// result channel: valid/ready plus result payload
interface vif_out_if;
  import vif_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] move_x;
  logic signed [DW-1:0] move_y;
  logic signed [DW-1:0] vel_x;
  logic signed [DW-1:0] vel_y;

  modport source (output valid, move_x, move_y, vel_x, vel_y, input ready);
  modport sink   (input valid, move_x, move_y, vel_x, vel_y, output ready);
endinterface

// ===== rtl/core/velocity_integrator_friction_core.sv =====
// top level of the two-axis velocity integrator with friction
//
//  channel  dir  handshake              payload
//  in_ch    in   valid/ready            func, time_step, vec_x, vec_y
//  out_ch   out  valid/ready            move_x, move_y, vel_x, vel_y
//  apb      in   psel/penable/pready    paddr, pwdata, pwrite, prdata
//
// one item in flight: a tick passes load, seven lane steps and the hand-off
// before its result enters the output register; other items go from load
// straight to the hand-off
// a write to force or mass holds off input while the serial divider of each
// lane it feeds refreshes force*65536/mass, one quotient bit per cycle
// reset restores all register defaults, zero speeds and a zero quotient
// the output register holds a finished result while the next item is loaded;
// a stalled output only holds the sequencer in its hand-off step
module velocity_integrator_friction_core (
  input  logic                              clk,
  input  logic                              rst_n,
  vif_in_if.sink                            in_ch,
  vif_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vif_pkg::ADDR_W-1:0]        paddr,
  input  logic [vif_pkg::DW-1:0]            pwdata,
  output logic [vif_pkg::DW-1:0]            prdata,
  output logic                              pready
);
  import vif_pkg::*;

  // configuration registers
  logic [DW-1:0]    force_x_r, force_y_r, mass_r, gravity_x_r, gravity_y_r;
  logic [LIM_W-1:0] friction_r, max_speed_x_r, max_speed_y_r;
  logic             div_start_x_r, div_start_x_nxt;
  logic             div_start_y_r, div_start_y_nxt;

  logic             cfg_wr;
  vif_reg_t         cfg_idx;

  // sequencer
  vif_state_t       state_r, state_nxt;
  vif_lane_ctrl_t   ctrl;
  logic             accept;
  logic             in_rdy;
  logic             push;
  logic             can_push;
  logic             limited;

  // lane results
  logic             busy_x, busy_y;
  logic [DW-1:0]    speed_x, speed_y, move_x, move_y;

  // ---------------------------------------------------------------------
  // apb register file, write strobe at the access phase
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = vif_reg_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_FORCE_X:     prdata = force_x_r;
      REG_FORCE_Y:     prdata = force_y_r;
      REG_MASS:        prdata = mass_r;
      REG_GRAVITY_X:   prdata = gravity_x_r;
      REG_GRAVITY_Y:   prdata = gravity_y_r;
      REG_FRICTION:    prdata = {1'b0, friction_r};
      REG_MAX_SPEED_X: prdata = {1'b0, max_speed_x_r};
      REG_MAX_SPEED_Y: prdata = {1'b0, max_speed_y_r};
    endcase
  end

  // quotient refresh starts the cycle after its operands change
  assign div_start_x_nxt = cfg_wr && ((cfg_idx == REG_FORCE_X) || (cfg_idx == REG_MASS));
  assign div_start_y_nxt = cfg_wr && ((cfg_idx == REG_FORCE_Y) || (cfg_idx == REG_MASS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_x_r     <= '0;
      force_y_r     <= '0;
      mass_r        <= DW'(65536);
      gravity_x_r   <= '0;
      gravity_y_r   <= '0;
      friction_r    <= '0;
      max_speed_x_r <= FULL_SCALE;
      max_speed_y_r <= FULL_SCALE;
      div_start_x_r <= 1'b0;
      div_start_y_r <= 1'b0;
    end else begin
      div_start_x_r <= div_start_x_nxt;
      div_start_y_r <= div_start_y_nxt;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_FORCE_X:     force_x_r     <= pwdata;
          REG_FORCE_Y:     force_y_r     <= pwdata;
          REG_MASS:        mass_r        <= pwdata;
          REG_GRAVITY_X:   gravity_x_r   <= pwdata;
          REG_GRAVITY_Y:   gravity_y_r   <= pwdata;
          REG_FRICTION:    friction_r    <= pwdata[LIM_W-1:0];
          REG_MAX_SPEED_X: max_speed_x_r <= pwdata[LIM_W-1:0];
          REG_MAX_SPEED_Y: max_speed_y_r <= pwdata[LIM_W-1:0];
        endcase
      end
    end
  end

  // either limit below full scale switches both axes to limited mode
  assign limited = (max_speed_x_r != FULL_SCALE) || (max_speed_y_r != FULL_SCALE);

  // ---------------------------------------------------------------------
  // step sequencer shared by both lanes
  // ---------------------------------------------------------------------
  assign accept = in_ch.valid && in_rdy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.func == FN_TICK) ? ST_ACC : ST_DONE;
        end
      end
      ST_ACC:  state_nxt = ST_DV;
      ST_DV:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_FRIC;
      ST_FRIC: state_nxt = ST_LIM;
      ST_LIM:  state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_MOVE;
      ST_MOVE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (can_push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    // no new item while a quotient is stale or a register write is under way
    in_rdy    = (state_r == ST_IDLE) && !busy_x && !busy_y &&
                !div_start_x_r && !div_start_y_r && !cfg_wr;
    ctrl      = '0;
    ctrl.load = in_ch.valid && in_rdy;
    ctrl.acc  = (state_r == ST_ACC);
    ctrl.dv   = (state_r == ST_DV);
    ctrl.sum  = (state_r == ST_SUM);
    ctrl.fric = (state_r == ST_FRIC);
    ctrl.lim  = (state_r == ST_LIM);
    ctrl.prod = (state_r == ST_PROD);
    ctrl.move = (state_r == ST_MOVE);
    push      = (state_r == ST_DONE) && can_push;
  end

  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // axis lanes
  // ---------------------------------------------------------------------
  vif_lane u_lane_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .func      (in_ch.func),
    .time_step (in_ch.time_step),
    .vec       (in_ch.vec_x),
    .force_val (force_x_r),
    .mass      (mass_r),
    .grav      (gravity_x_r),
    .friction  (friction_r),
    .limit     (max_speed_x_r),
    .limited   (limited),
    .div_start (div_start_x_r),
    .div_busy  (busy_x),
    .speed     (speed_x),
    .move      (move_x)
  );

  vif_lane u_lane_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .func      (in_ch.func),
    .time_step (in_ch.time_step),
    .vec       (in_ch.vec_y),
    .force_val (force_y_r),
    .mass      (mass_r),
    .grav      (gravity_y_r),
    .friction  (friction_r),
    .limit     (max_speed_y_r),
    .limited   (limited),
    .div_start (div_start_y_r),
    .div_busy  (busy_y),
    .speed     (speed_y),
    .move      (move_y)
  );

  // ---------------------------------------------------------------------
  // result merge and output register
  // ---------------------------------------------------------------------
  vif_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .move_x   (move_x),
    .move_y   (move_y),
    .vel_x    (speed_x),
    .vel_y    (speed_y),
    .can_push (can_push),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  // only one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second item taken while one is in flight");

  // a tick enters the lane step sequence
  a_tick_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && (in_ch.func == FN_TICK) |=> state_r == ST_ACC)
    else $error("tick did not start the lane steps");

  // a quotient refresh blocks input
  a_div_block: assert property (@(posedge clk) disable iff (!rst_n)
    (div_start_x_r || div_start_y_r || busy_x || busy_y) |-> !in_ch.ready)
    else $error("item taken during quotient refresh");

  // a finished result goes straight into an empty output register
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && !out_ch.valid |=> out_ch.valid)
    else $error("result not handed to an empty output register");
`endif

endmodule

// ===== rtl/core/vif_div.sv =====
// radix-2 restoring divider for force*65536/mass, saturated to 32 bits
module vif_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [vif_pkg::DW-1:0] force_val,
  input  logic [vif_pkg::DW-1:0]        mass,
  output logic                          busy,
  output logic signed [vif_pkg::DW-1:0] quo
);
  import vif_pkg::*;

  localparam int unsigned QW    = DW + 16;
  localparam int unsigned CNT_W = $clog2(QW);
  localparam logic [QW-1:0] NEG_LIM = QW'(1) << (DW - 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             fin_r, fin_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    dvd_r, dvd_nxt;
  logic             neg_r, neg_nxt;
  logic [DW-1:0]    div_r, div_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;

  logic [DW:0]      rem_sh;
  logic [DW+1:0]    diff;
  logic             qbit;
  logic [DW-1:0]    fmag;

  assign fmag   = force_val[DW-1] ? (~force_val + DW'(1)) : force_val;
  assign rem_sh = {rem_r, dvd_r[QW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_r};
  assign qbit   = ~diff[DW+1];

  always_comb begin
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    fin_nxt = 1'b0;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    neg_nxt = neg_r;
    div_nxt = div_r;
    quo_nxt = quo_r;
    priority if (start) begin
      cnt_nxt = '0;
      run_nxt = 1'b1;
      rem_nxt = '0;
      dvd_nxt = {fmag, 16'h0000};
      neg_nxt = force_val[DW-1];
      // zero mass counts as the smallest mass
      div_nxt = (mass == '0) ? DW'(1) : mass;
    end else if (run_r) begin
      rem_nxt = qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
      dvd_nxt = {dvd_r[QW-2:0], qbit};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(QW - 1)) begin
        run_nxt = 1'b0;
        fin_nxt = 1'b1;
      end
    end else if (fin_r) begin
      if (!neg_r) begin
        quo_nxt = (|dvd_r[QW-1:DW-1]) ? {1'b0, {(DW-1){1'b1}}} : dvd_r[DW-1:0];
      end else begin
        quo_nxt = (dvd_r > NEG_LIM) ? {1'b1, {(DW-1){1'b0}}}
                                    : (~dvd_r[DW-1:0] + DW'(1));
      end
    end else begin
      quo_nxt = quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
      quo_r <= '0;
    end else begin
      run_r <= run_nxt;
      fin_r <= fin_nxt;
      quo_r <= quo_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    neg_r <= neg_nxt;
    div_r <= div_nxt;
  end

  assign busy = run_r | fin_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/core/vif_lane.sv =====
// one axis lane: speed state, tick datapath and its force/mass quotient
module vif_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vif_pkg::vif_lane_ctrl_t       ctrl,
  input  vif_pkg::vif_func_t            func,
  input  logic [vif_pkg::DT_W-1:0]      time_step,
  input  logic signed [vif_pkg::DW-1:0] vec,
  input  logic signed [vif_pkg::DW-1:0] force_val,
  input  logic [vif_pkg::DW-1:0]        mass,
  input  logic signed [vif_pkg::DW-1:0] grav,
  input  logic [vif_pkg::LIM_W-1:0]     friction,
  input  logic [vif_pkg::LIM_W-1:0]     limit,
  input  logic                          limited,
  input  logic                          div_start,
  output logic                          div_busy,
  output logic signed [vif_pkg::DW-1:0] speed,
  output logic signed [vif_pkg::DW-1:0] move
);
  import vif_pkg::*;

  localparam int unsigned PW = DW + DT_W;

  logic [DW-1:0]    quo;
  logic [DT_W-1:0]  dt_r, dt_nxt;
  logic [DW-1:0]    speed_r, speed_nxt;
  logic [DW-1:0]    move_r, move_nxt;
  logic [DW-1:0]    acc_r, acc_nxt;
  logic [LIM_W-1:0] fdt_r, fdt_nxt;
  logic [LIM_W-1:0] dvm_r, dvm_nxt;
  logic             dvneg_r, dvneg_nxt;
  logic [DW-1:0]    s1_r, s1_nxt;
  logic [DW-1:0]    s2_r, s2_nxt;
  logic [DW-1:0]    s3_r, s3_nxt;
  logic [LIM_W-1:0] pm_r, pm_nxt;
  logic             pneg_r, pneg_nxt;

  logic [PW-2:0]    fdt_prod;
  logic [DW-1:0]    acc_mag;
  logic [PW-1:0]    dv_prod;
  logic [DW:0]      dv_ext;
  logic [DW:0]      sub33;
  logic [DW:0]      add33;
  logic [DW:0]      mag33;
  logic             lt_db;
  logic signed [DW:0] tt33;
  logic signed [DW:0] lim33;
  logic [DW-1:0]    s3_mag;
  logic [PW-1:0]    pm_prod;
  logic [DW-1:0]    db_prod;
  logic             db_hit;

  vif_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .force_val (force_val),
    .mass      (mass),
    .busy      (div_busy),
    .quo       (quo)
  );

  // acceleration and friction per step
  assign acc_nxt  = sat33({quo[DW-1], quo} + {grav[DW-1], grav});
  assign fdt_prod = (PW-1)'(friction) * (PW-1)'(dt_r);
  assign fdt_nxt  = fdt_prod[PW-2:16];

  // velocity change, magnitude times dt, sign restored later
  assign acc_mag   = acc_r[DW-1] ? (~acc_r + DW'(1)) : acc_r;
  assign dv_prod   = PW'(acc_mag) * PW'(dt_r);
  assign dvm_nxt   = dv_prod[PW-2:16];
  assign dvneg_nxt = acc_r[DW-1];

  assign dv_ext = dvneg_r ? (~{2'b00, dvm_r} + (DW+1)'(1)) : {2'b00, dvm_r};
  assign s1_nxt = sat33({speed_r[DW-1], speed_r} + dv_ext);

  // friction toward zero, zero on overshoot
  assign sub33 = {s1_r[DW-1], s1_r} - {2'b00, fdt_r};
  assign add33 = {s1_r[DW-1], s1_r} + {2'b00, fdt_r};

  always_comb begin
    priority if (!s1_r[DW-1] && (s1_r != '0) && !sub33[DW] && (sub33 != '0)) begin
      s2_nxt = sub33[DW-1:0];
    end else if (s1_r[DW-1] && add33[DW]) begin
      s2_nxt = add33[DW-1:0];
    end else begin
      s2_nxt = '0;
    end
  end

  // limited mode: deadband on speed, then clamp to the limit
  assign mag33 = s2_r[DW-1] ? (~{s2_r[DW-1], s2_r} + (DW+1)'(1)) : {1'b0, s2_r};
  assign lt_db = mag33 < (DW+1)'(DEADBAND);
  assign tt33  = lt_db ? (DW+1)'(DEADBAND) : {s2_r[DW-1], s2_r};
  assign lim33 = {2'b00, limit};

  always_comb begin
    priority if (!limited) begin
      s3_nxt = s2_r;
    end else if (tt33 > lim33) begin
      s3_nxt = {1'b0, limit};
    end else if (tt33 < -lim33) begin
      s3_nxt = ~{1'b0, limit} + DW'(1);
    end else begin
      s3_nxt = tt33[DW-1:0];
    end
  end

  // displacement magnitude
  assign s3_mag   = s3_r[DW-1] ? (~s3_r + DW'(1)) : s3_r;
  assign pm_prod  = PW'(s3_mag) * PW'(dt_r);
  assign pm_nxt   = pm_prod[PW-2:16];
  assign pneg_nxt = s3_r[DW-1];

  // unlimited mode: deadband on displacement
  assign db_prod = DW'(DEADBAND) * DW'(dt_r);
  assign db_hit  = !limited && (pm_r < LIM_W'(DEADBAND));

  always_comb begin
    dt_nxt    = dt_r;
    speed_nxt = speed_r;
    move_nxt  = move_r;
    priority if (ctrl.load) begin
      dt_nxt   = time_step;
      move_nxt = '0;
      unique case (func)
        FN_TICK:    speed_nxt = speed_r;
        FN_IMPULSE: speed_nxt = sat33({speed_r[DW-1], speed_r} + {vec[DW-1], vec});
        FN_SET:     speed_nxt = vec;
        FN_STOP:    speed_nxt = '0;
      endcase
    end else if (ctrl.move) begin
      if (db_hit) begin
        speed_nxt = DW'(DEADBAND);
        move_nxt  = {{(DW-16){1'b0}}, db_prod[DW-1:16]};
      end else begin
        speed_nxt = s3_r;
        move_nxt  = pneg_r ? (~{1'b0, pm_r} + DW'(1)) : {1'b0, pm_r};
      end
    end else begin
      speed_nxt = speed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
    end else begin
      speed_r <= speed_nxt;
    end
    dt_r   <= dt_nxt;
    move_r <= move_nxt;
    if (ctrl.acc) begin
      acc_r <= acc_nxt;
      fdt_r <= fdt_nxt;
    end
    if (ctrl.dv) begin
      dvm_r   <= dvm_nxt;
      dvneg_r <= dvneg_nxt;
    end
    if (ctrl.sum) begin
      s1_r <= s1_nxt;
    end
    if (ctrl.fric) begin
      s2_r <= s2_nxt;
    end
    if (ctrl.lim) begin
      s3_r <= s3_nxt;
    end
    if (ctrl.prod) begin
      pm_r   <= pm_nxt;
      pneg_r <= pneg_nxt;
    end
  end

  assign speed = speed_r;
  assign move  = move_r;

endmodule

// ===== rtl/core/vif_merge.sv =====
// merges both lane results into one output register
module vif_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic signed [vif_pkg::DW-1:0] move_x,
  input  logic signed [vif_pkg::DW-1:0] move_y,
  input  logic signed [vif_pkg::DW-1:0] vel_x,
  input  logic signed [vif_pkg::DW-1:0] vel_y,
  output logic                          can_push,
  vif_out_if.source                     out_ch
);
  import vif_pkg::*;

  logic          valid_r, valid_nxt;
  logic [DW-1:0] move_x_r, move_y_r, vel_x_r, vel_y_r;

  assign can_push = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    priority if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (push) begin
      move_x_r <= move_x;
      move_y_r <= move_y;
      vel_x_r  <= vel_x;
      vel_y_r  <= vel_y;
    end
  end

  assign out_ch.valid  = valid_r;
  assign out_ch.move_x = move_x_r;
  assign out_ch.move_y = move_y_r;
  assign out_ch.vel_x  = vel_x_r;
  assign out_ch.vel_y  = vel_y_r;

endmodule

// ===== tb/sv/velocity_step_checker.sv =====
// checker for the velocity integrator: predicts each result and compares it
module velocity_step_checker
  import vif_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  vif_in_if                    in_ch,
  vif_out_if                   out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DW-1:0]        pwdata,
  input  logic                 pready,
  input  logic                 run_done,
  output int                   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [DW-1:0] move_x;
    logic signed [DW-1:0] move_y;
    logic signed [DW-1:0] vel_x;
    logic signed [DW-1:0] vel_y;
  } motion_t;

  // shadow of the register file and the body state
  logic signed [DW-1:0]    force_x, force_y, gravity_x, gravity_y;
  logic [DW-1:0]           mass_q;
  logic [LIM_W-1:0]        friction_q, max_x, max_y;
  logic signed [DW-1:0]    speed_x, speed_y;

  motion_t pending_motion [$];
  motion_t want, got;
  logic    wrapped_up;

  initial fail_count = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // a * dt >> 16 on the magnitude, sign put back afterwards
  function automatic longint scale_by_dt(input longint a, input logic [DT_W-1:0] dt);
    longint unsigned mag;
    longint unsigned prod;
    mag  = longint'(magnitude(a));
    prod = (mag * 64'(dt)) >> 16;
    return (a < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  // one axis of a tick: accelerate, rub off friction, deadband, limit
  function automatic logic signed [DW-1:0] advance_axis(
    input  logic signed [DW-1:0] speed,
    input  logic signed [DW-1:0] force_v,
    input  logic signed [DW-1:0] grav,
    input  logic [LIM_W-1:0]     limit,
    input  logic                 limited,
    input  logic [DT_W-1:0]      dt,
    output logic signed [DW-1:0] move
  );
    longint divisor, quot, acc, s, fdt;
    divisor = (mass_q == '0) ? 64'sd1 : longint'(mass_q);
    quot    = (longint'(force_v) * 64'sd65536) / divisor;
    acc     = clamp32(clamp32(quot) + longint'(grav));
    s       = clamp32(longint'(speed) + scale_by_dt(acc, dt));
    fdt     = longint'((64'(friction_q) * 64'(dt)) >> 16);

    // friction pulls toward zero but never flips the sign
    if (s > 0 && s - fdt > 0) begin
      s = s - fdt;
    end else if (s < 0 && s + fdt < 0) begin
      s = s + fdt;
    end else begin
      s = 0;
    end

    if (limited) begin
      if (magnitude(s) < longint'(DEADBAND)) s = longint'(DEADBAND);
      if (s > longint'(limit)) s = longint'(limit);
      if (s < -longint'(limit)) s = -longint'(limit);
    end else if (magnitude(scale_by_dt(s, dt)) < longint'(DEADBAND)) begin
      s = longint'(DEADBAND);
    end

    s    = clamp32(s);
    move = 32'(clamp32(scale_by_dt(s, dt)));
    return 32'(s);
  endfunction

  // expected result of one item, speeds updated on the way
  function automatic motion_t predict_motion(
    input vif_func_t            fn,
    input logic [DT_W-1:0]      dt,
    input logic signed [DW-1:0] vx,
    input logic signed [DW-1:0] vy
  );
    motion_t r;
    logic    limited;
    r = '0;
    case (fn)
      FN_TICK: begin
        limited = (max_x != FULL_SCALE) || (max_y != FULL_SCALE);
        speed_x = advance_axis(speed_x, force_x, gravity_x, max_x, limited, dt, r.move_x);
        speed_y = advance_axis(speed_y, force_y, gravity_y, max_y, limited, dt, r.move_y);
      end
      FN_IMPULSE: begin
        speed_x = 32'(clamp32(longint'(speed_x) + longint'(vx)));
        speed_y = 32'(clamp32(longint'(speed_y) + longint'(vy)));
      end
      FN_SET: begin
        speed_x = vx;
        speed_y = vy;
      end
      default: begin
        speed_x = '0;
        speed_y = '0;
      end
    endcase
    r.vel_x = speed_x;
    r.vel_y = speed_y;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      force_x    = '0;
      force_y    = '0;
      mass_q     = 32'h0001_0000;
      gravity_x  = '0;
      gravity_y  = '0;
      friction_q = '0;
      max_x      = FULL_SCALE;
      max_y      = FULL_SCALE;
      speed_x    = '0;
      speed_y    = '0;
      wrapped_up = 1'b0;
      pending_motion.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (vif_reg_t'(paddr[ADDR_W-1:2]))
          REG_FORCE_X:     force_x    = pwdata;
          REG_FORCE_Y:     force_y    = pwdata;
          REG_MASS:        mass_q     = pwdata;
          REG_GRAVITY_X:   gravity_x  = pwdata;
          REG_GRAVITY_Y:   gravity_y  = pwdata;
          REG_FRICTION:    friction_q = pwdata[LIM_W-1:0];
          REG_MAX_SPEED_X: max_x      = pwdata[LIM_W-1:0];
          default:         max_y      = pwdata[LIM_W-1:0];
        endcase
      end

      // results first, so a result never meets its own item's prediction
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.move_x, out_ch.move_y, out_ch.vel_x, out_ch.vel_y};
        if (pending_motion.size() == 0) begin
          report_mismatch($sformatf("unexpected result vel %0d,%0d",
                                    got.vel_x, got.vel_y));
        end else begin
          want = pending_motion.pop_front();
          if (got.move_x !== want.move_x)
            report_mismatch($sformatf("move_x %0d, want %0d", got.move_x, want.move_x));
          if (got.move_y !== want.move_y)
            report_mismatch($sformatf("move_y %0d, want %0d", got.move_y, want.move_y));
          if (got.vel_x !== want.vel_x)
            report_mismatch($sformatf("vel_x %0d, want %0d", got.vel_x, want.vel_x));
          if (got.vel_y !== want.vel_y)
            report_mismatch($sformatf("vel_y %0d, want %0d", got.vel_y, want.vel_y));
        end
      end

      if (in_ch.valid && in_ch.ready)
        pending_motion.push_back(predict_motion(in_ch.func, in_ch.time_step,
                                                in_ch.vec_x, in_ch.vec_y));

      if (run_done && !wrapped_up) begin
        wrapped_up = 1'b1;
        if (pending_motion.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", pending_motion.size()));
      end
    end
  end

endmodule

// ===== tb/sv/velocity_integrator_friction_core_test.sv =====
// top of the velocity integrator testbench: stimulus, handshake pacing, verdict
module velocity_integrator_friction_core_test;
  import vif_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // idle padding after the last result, a little extra for hand-off
  localparam int LATENCY_PAD     = 16;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int PRESSURE_PHASE  = 2;
  localparam int HOLD_CYCLES     = 240;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DW-1:0]       pwdata;
  logic [DW-1:0]       prdata;
  logic                pready;
  logic                run_done;
  int                  fail_count;

  // pacing shared by the sender and the receiver
  bit                  steady_in;
  bit                  steady_out;
  bit                  hold_request;
  int                  items_sent;
  int                  results_seen;

  vif_in_if  in_if ();
  vif_out_if out_if ();

  velocity_integrator_friction_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  velocity_step_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .run_done   (run_done),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // slowest clean run is about 290 us: every item with the longest input
  // gap, the full tick step sequence and the longest output stall,
  // plus per-phase divider refresh and the long hold; allow over ten times that
  initial begin
    #4_000_000;
    $display("velocity_integrator_friction_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // random value pickers, weighted toward the edges of each field
  // ---------------------------------------------------------------------------

  // signed q16.16: rails, zero, small and mid physical values, raw noise
  function automatic logic [31:0] pick_signed_q16();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3, 4, 5: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      6, 7:    return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
      default: return $urandom();
    endcase
  endfunction

  // mass: zero is treated as the smallest mass by the block
  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0001_0000;
      3:       return 32'h0000_0001;
      default: return 32'($urandom_range(32'h0000_4000, 32'h0010_0000));
    endcase
  endfunction

  function automatic logic [30:0] pick_friction();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return FULL_SCALE;
      2, 3, 4: return 31'($urandom_range(0, 32'h0008_0000));
      default: return 31'($urandom());
    endcase
  endfunction

  // a limit below full scale puts both axes into limited mode
  function automatic logic [30:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return FULL_SCALE;
      1:       return '0;
      2, 3, 4: return 31'($urandom_range(1, 32'h000A_0000));
      default: return 31'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------

  // setup then access; the bus stays in access so back-to-back writes never
  // drive psel twice in one step, the caller parks it afterwards
  task automatic cfg_write(input vif_reg_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_config(
    input logic [31:0] fx, input logic [31:0] fy, input logic [31:0] m,
    input logic [31:0] gx, input logic [31:0] gy, input logic [30:0] fr,
    input logic [30:0] lim_x, input logic [30:0] lim_y
  );
    cfg_write(REG_FORCE_X, fx);
    cfg_write(REG_FORCE_Y, fy);
    cfg_write(REG_MASS, m);
    cfg_write(REG_GRAVITY_X, gx);
    cfg_write(REG_GRAVITY_Y, gy);
    cfg_write(REG_FRICTION, {1'b0, fr});
    cfg_write(REG_MAX_SPEED_X, {1'b0, lim_x});
    cfg_write(REG_MAX_SPEED_Y, {1'b0, lim_y});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // input channel
  // ---------------------------------------------------------------------------

  // one item: optional gap with valid low, then hold until the transfer
  task automatic offer_item(
    input vif_func_t   fn,
    input logic [15:0] dt,
    input logic [31:0] vx,
    input logic [31:0] vy
  );
    int gap;
    gap = steady_in ? 0 : int'($urandom_range(0, 11));
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= fn;
    in_if.time_step <= dt;
    in_if.vec_x     <= vx;
    in_if.vec_y     <= vy;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  // mostly ticks, so speeds carry over long chains of physics steps
  task automatic offer_random_item();
    vif_func_t   fn;
    logic [15:0] dt;
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4, 5, 6: fn = FN_TICK;
      7, 8:                fn = FN_IMPULSE;
      9, 10:               fn = FN_SET;
      default:             fn = FN_STOP;
    endcase
    case ($urandom_range(0, 7))
      0:       dt = '0;
      1:       dt = '1;
      2, 3, 4: dt = 16'($urandom_range(0, 2048));
      default: dt = 16'($urandom());
    endcase
    offer_item(fn, dt, pick_signed_q16(), pick_signed_q16());
  endtask

  // park the input, wait for every result, then let the core go quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result channel: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      int stall;
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = steady_out ? 0 : int'($urandom_range(0, 11));
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [30:0] lim_x, lim_y;

    // every input known from the first step
    rst_n           <= 1'b0;
    run_done        <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_if.valid     <= 1'b0;
    in_if.func      <= FN_TICK;
    in_if.time_step <= '0;
    in_if.vec_x     <= '0;
    in_if.vec_y     <= '0;
    steady_in       = 1'b0;
    steady_out      = 1'b0;
    hold_request    = 1'b0;
    items_sent      = 0;
    results_seen    = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: no force, unit mass, unlimited
    // zero time step with speed zero snaps both speeds to the deadband
    offer_item(FN_TICK, 16'h0000, $urandom(), $urandom());
    offer_item(FN_SET, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000);
    offer_item(FN_TICK, 16'hFFFF, $urandom(), $urandom());
    // impulse past both rails saturates
    offer_item(FN_IMPULSE, 16'h0000, 32'h0000_0001, 32'hFFFF_FFFF);
    offer_item(FN_IMPULSE, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF);
    offer_item(FN_STOP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_item(FN_SET, 16'h0000, 32'hFFFC_8000, 32'h0002_4000);
    offer_item(FN_TICK, 16'h0444, $urandom(), $urandom());
    offer_item(FN_TICK, 16'h8000, $urandom(), $urandom());
    settle();

    // all registers at extremes: zero mass, rails on force and gravity,
    // full friction, x limit zero puts the body in limited mode
    load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, FULL_SCALE, '0, FULL_SCALE);
    offer_item(FN_TICK, 16'hFFFF, $urandom(), $urandom());
    offer_item(FN_SET, 16'h0000, 32'h0001_0000, 32'hFFFF_0000);
    offer_item(FN_TICK, 16'h0000, $urandom(), $urandom());
    offer_item(FN_STOP, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    offer_item(FN_TICK, 16'h0001, $urandom(), $urandom());
    settle();

    // a plausible body: small speeds against friction overshoot to zero,
    // then the deadband, then fast speeds against the limits
    load_config(32'h0001_0000, 32'hFFFE_0000, 32'h0002_0000,
                32'h0000_0000, 32'hFFF6_3333, 31'h0000_8000,
                31'h0005_0000, 31'h0003_0000);
    offer_item(FN_SET, 16'h0000, 32'h0000_1999, 32'hFFFF_E667);
    offer_item(FN_TICK, 16'h8000, $urandom(), $urandom());
    offer_item(FN_TICK, 16'h0444, $urandom(), $urandom());
    offer_item(FN_SET, 16'h0000, 32'h0010_0000, 32'hFFF0_0000);
    offer_item(FN_TICK, 16'h0444, $urandom(), $urandom());
    offer_item(FN_IMPULSE, 16'h0000, 32'h0000_0001, 32'hFFFF_FFFF);
    offer_item(FN_TICK, 16'hFFFF, $urandom(), $urandom());
    offer_item(FN_STOP, 16'h0000, $urandom(), $urandom());
    settle();

    // random phases, each with its own register setting and pacing
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // unlimited mode needs both limits at full scale, so give it real weight
      if ($urandom_range(0, 4) < 2) begin
        lim_x = FULL_SCALE;
        lim_y = FULL_SCALE;
      end else begin
        lim_x = pick_limit();
        lim_y = pick_limit();
      end
      load_config(pick_signed_q16(), pick_signed_q16(), pick_mass(),
                  pick_signed_q16(), pick_signed_q16(), pick_friction(), lim_x, lim_y);

      steady_in  = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);

      // receiver goes quiet for a long stretch while items keep coming,
      // so the output register fills and input ready drops
      if (phase == PRESSURE_PHASE) begin
        steady_in    = 1'b1;
        steady_out   = 1'b0;
        hold_request = 1'b1;
      end

      repeat (ITEMS_PER_PHASE) offer_random_item();
      settle();
    end

    // let the checker look for leftovers, then give the verdict
    steady_in  = 1'b0;
    steady_out = 1'b0;
    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("velocity_integrator_friction_core verification clean");
    end else begin
      $display("velocity_integrator_friction_core verification failed");
    end
    $finish;
  end

endmodule
